@@ hdl/fsfb_pkg.sv @@
// ----------------------------------------------------------------------------
// fsfb_pkg
// Widths, constants and unit interface types for the balance controller.
// ----------------------------------------------------------------------------
package fsfb_pkg;

   localparam int DT_W    = 20;   // step time in microseconds
   localparam int NUM_W   = 54;   // |difference| * 1e6
   localparam int QUOT_W  = 47;   // raw rate magnitude, Q.16
   localparam int MUL_A_W = 49;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [MUL_B_W-1:0] US_PER_S = 32'd1000000;
   localparam logic [16:0]        HALF_Q16 = 17'd32768;

   typedef struct packed {
      logic              done;
      logic              ovf;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

@@ hdl/fsfb_mul.sv @@
// ----------------------------------------------------------------------------
// fsfb_mul
// Unsigned multiplier, one 16-bit digit of b per cycle.
// ----------------------------------------------------------------------------
module fsfb_mul
   import fsfb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic               done,
   output logic [MUL_P_W-1:0] prod
);

   logic [MUL_A_W-1:0] a_ff;
   logic [15:0]        b_hi_ff;
   logic [MUL_P_W-1:0] acc_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [MUL_A_W+15:0] pp;

   always_comb begin
      if (busy_ff) begin
         pp = a_ff * b_hi_ff;
      end else begin
         pp = a * b[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff;
         if (start) begin
            busy_ff <= 1'b1;
         end else begin
            busy_ff <= 1'b0;
         end
      end
      if (start) begin
         a_ff    <= a;
         b_hi_ff <= b[31:16];
         acc_ff  <= MUL_P_W'(pp);
      end else if (busy_ff) begin
         acc_ff <= acc_ff + {pp, 16'b0};
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

@@ hdl/fsfb_div.sv @@
// ----------------------------------------------------------------------------
// fsfb_div
// Restoring divider: floor(num * 2^16 / dt), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsfb_div
   import fsfb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DT_W-1:0]  dt,
   output div_rsp_type      rsp
);

   logic              busy_ff;
   logic              done_ff;
   logic              ovf_ff;
   logic [5:0]        cnt_ff;
   logic [DT_W-1:0]   rem_ff;
   logic [DT_W-1:0]   dt_ff;
   logic [QUOT_W-1:0] sh_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [DT_W:0]     trial;
   logic              ge;
   logic              ovf_in;

   // quotient would need 32 or more integer bits
   assign ovf_in = num[NUM_W-1:31] >= (NUM_W-31)'(dt);
   assign trial  = {rem_ff, sh_ff[QUOT_W-1]};
   assign ge     = trial >= {1'b0, dt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= !ovf_in;
            done_ff <= ovf_in;
         end else if (busy_ff && cnt_ff == 6'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         ovf_ff  <= ovf_in;
         dt_ff   <= dt;
         rem_ff  <= num[DT_W+30:31];
         sh_ff   <= {num[30:0], 16'b0};
         quot_ff <= '0;
         cnt_ff  <= 6'(QUOT_W);
      end else if (busy_ff) begin
         rem_ff  <= ge ? DT_W'(trial - {1'b0, dt_ff}) : DT_W'(trial);
         quot_ff <= {quot_ff[QUOT_W-2:0], ge};
         sh_ff   <= {sh_ff[QUOT_W-2:0], 1'b0};
         cnt_ff  <= cnt_ff - 6'd1;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.ovf  = ovf_ff;
   assign rsp.quot = quot_ff;

endmodule

@@ hdl/full_state_feedback_balance.sv @@
// ----------------------------------------------------------------------------
// full_state_feedback_balance
// Balance controller: velocity and tilt acceleration estimates, five
// clamped gain terms, limited and rounded drive.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | encoder counts, tilt, rate, dt
//  rsp     | out       | rsp_valid/rsp_stall | drive, flags, estimates
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
//  A valid sample runs two divisions of up to 47 steps in the divider and nine
//  passes through the shared multiplier.
//  An invalid or restart sample gives its result on the next cycle.
//  One sample at a time; req_stall is high from acceptance until the result
//  transfers. Reset is synchronous and clears history, configuration and control state.
// ----------------------------------------------------------------------------
module full_state_feedback_balance
   import fsfb_pkg::*;
#(
   parameter int DEFAULT_PERIOD_US = 10000,
   parameter int MAX_STEP_US       = 100000,
   parameter int MAX_DRIVE         = 4095
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_left_count,
   input  logic signed [31:0] req_right_count,
   input  logic signed [16:0] req_tilt_angle,
   input  logic signed [16:0] req_tilt_setpoint,
   input  logic signed [15:0] req_tilt_rate,
   input  logic [19:0]        req_step_time_us,
   input  logic               req_sample_valid,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [12:0] rsp_drive,
   output logic               rsp_saturated,
   output logic signed [15:0] rsp_unlimited_sum,
   output logic signed [31:0] rsp_velocity_estimate,
   output logic signed [31:0] rsp_accel_estimate,
   output logic               rsp_held,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam logic [2:0] REG_GAIN_POS   = 3'd0;
   localparam logic [2:0] REG_GAIN_VEL   = 3'd1;
   localparam logic [2:0] REG_GAIN_ANG   = 3'd2;
   localparam logic [2:0] REG_GAIN_RATE  = 3'd3;
   localparam logic [2:0] REG_GAIN_ACC   = 3'd4;
   localparam logic [2:0] REG_VEL_BETA   = 3'd5;
   localparam logic [2:0] REG_ACC_BETA   = 3'd6;
   localparam logic [2:0] REG_OUT_LIMIT  = 3'd7;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RUN  = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   localparam logic [3:0] STEP_VNUM = 4'd0;
   localparam logic [3:0] STEP_VDIV = 4'd1;
   localparam logic [3:0] STEP_VFLT = 4'd2;
   localparam logic [3:0] STEP_ANUM = 4'd3;
   localparam logic [3:0] STEP_ADIV = 4'd4;
   localparam logic [3:0] STEP_AFLT = 4'd5;
   localparam logic [3:0] STEP_TPOS = 4'd6;
   localparam logic [3:0] STEP_TVEL = 4'd7;
   localparam logic [3:0] STEP_TANG = 4'd8;
   localparam logic [3:0] STEP_TRATE = 4'd9;
   localparam logic [3:0] STEP_TACC = 4'd10;

   localparam logic [DT_W-1:0] DEF_DT  = DT_W'(DEFAULT_PERIOD_US);
   localparam logic [DT_W:0]   MAX_DT  = (DT_W+1)'(MAX_STEP_US);
   localparam logic [47:0]     RAW_MAX = {1'b0, {QUOT_W{1'b1}}};

   // configuration
   logic signed [31:0] gain_pos_ff, gain_vel_ff, gain_ang_ff, gain_rate_ff, gain_acc_ff;
   logic [16:0]        vel_beta_ff, acc_beta_ff, beta_in;
   logic [11:0]        out_limit_ff;

   // history
   logic signed [32:0] last_pos_ff;
   logic signed [15:0] last_rate_ff;
   logic signed [47:0] sv_ff, sa_ff;
   logic               primed_ff;

   // sample and working registers
   logic signed [32:0] pos_ff;
   logic signed [17:0] adiff_ff;
   logic signed [15:0] rate_ff;
   logic [DT_W-1:0]    dt_ff;
   logic signed [47:0] raw_ff;
   logic signed [31:0] sum_ff;
   logic               sat_ff;
   logic [2:0]         state_ff;
   logic [3:0]         step_ff;

   // result registers
   logic               rsp_valid_ff;
   logic signed [12:0] drive_ff;
   logic               satd_ff;
   logic signed [15:0] usum_ff;
   logic signed [31:0] vest_ff, aest_ff;
   logic               held_ff;

   // units
   logic               mul_start, mul_done;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_prod;
   logic               div_start;
   div_rsp_type        div_rsp;

   // datapath
   logic signed [32:0] pos_in;
   logic               bad_dt;
   logic signed [33:0] vdiff;
   logic signed [16:0] rdiff;
   logic [33:0]        vdiff_mag;
   logic [16:0]        rdiff_mag;
   logic               diff_neg;
   logic [47:0]        raw_mag;
   logic signed [48:0] fdiff;
   logic [48:0]        fdiff_mag;
   logic [48:0]        fstep;
   logic signed [47:0] filt_s;
   logic signed [48:0] filt_new;
   logic signed [31:0] gain_sel;
   logic [31:0]        gain_mag;
   logic [47:0]        x_mag;
   logic               x_neg;
   logic [MUL_P_W:0]   t_round;
   logic [MUL_P_W:0]   t_shift;
   logic [27:0]        lim;
   logic [28:0]        lim_sat;
   logic               t_big;
   logic               t_gt_lim, t_gt_sat;
   logic [27:0]        t_mag;
   logic signed [31:0] term;
   logic               unit_done;

   logic [11:0]        limit;
   logic [30:0]        sum_mag;
   logic [30:0]        clip_mag;
   logic [31:0]        drive_r;
   logic [31:0]        usum_r;
   logic [47:0]        sa_mag;
   logic [48:0]        sa_r;
   logic signed [12:0] drive_in;
   logic signed [15:0] usum_in;
   logic signed [31:0] vest_in, aest_in;
   logic               sat_in;

   fsfb_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   fsfb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (mul_prod[NUM_W-1:0]),
      .dt    (dt_ff),
      .rsp   (div_rsp)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);

   // writes saturate the smoothing coefficient into [1, 65536], i.e. up to 1.0
   always_comb begin
      if (csr_data[16:0] == 17'd0) begin
         beta_in = 17'd1;
      end else if (csr_data[16:0] > 17'd65536) begin
         beta_in = 17'd65536;
      end else begin
         beta_in = csr_data[16:0];
      end
   end

   assign limit   = (32'(out_limit_ff) < 32'(MAX_DRIVE)) ? out_limit_ff : 12'(MAX_DRIVE);
   assign lim     = {limit, 16'b0};
   assign lim_sat = {1'b0, lim} + 29'(HALF_Q16);

   assign pos_in = 33'(req_left_count) + 33'(req_right_count);
   assign bad_dt = (req_step_time_us == '0) || ({1'b0, req_step_time_us} > MAX_DT);

   assign vdiff     = 34'(pos_ff) - 34'(last_pos_ff);
   assign rdiff     = 17'(rate_ff) - 17'(last_rate_ff);
   assign vdiff_mag = vdiff[33] ? 34'(-vdiff) : 34'(vdiff);
   assign rdiff_mag = rdiff[16] ? 17'(-rdiff) : 17'(rdiff);

   always_comb begin
      diff_neg = (step_ff == STEP_VDIV) ? vdiff[33] : rdiff[16];
      raw_mag  = div_rsp.ovf ? RAW_MAX : {1'b0, div_rsp.quot};
      filt_s   = (step_ff == STEP_VFLT) ? sv_ff : sa_ff;
      fdiff    = 49'(raw_ff) - 49'(filt_s);
      fdiff_mag = fdiff[48] ? 49'(-fdiff) : 49'(fdiff);
      fstep    = 49'((mul_prod[64:0] + 65'(HALF_Q16)) >> 16);
      filt_new = fdiff[48] ? 49'(filt_s) - 49'(fstep) : 49'(filt_s) + 49'(fstep);
   end

   // operand selection for the term being formed
   always_comb begin
      gain_sel = gain_pos_ff;
      x_mag    = '0;
      x_neg    = 1'b0;
      t_round  = '0;
      t_shift  = '0;
      case (step_ff)
         STEP_TPOS: begin
            gain_sel = gain_pos_ff;
            x_neg    = pos_ff[32];
            x_mag    = pos_ff[32] ? 48'(-34'(pos_ff)) : 48'(pos_ff);
            t_round  = (MUL_P_W+1)'(mul_prod) + (MUL_P_W+1)'(1);
            t_shift  = t_round >> 1;
         end
         STEP_TVEL: begin
            gain_sel = gain_vel_ff;
            x_neg    = sv_ff[47];
            x_mag    = sv_ff[47] ? 48'(-sv_ff) : 48'(sv_ff);
            t_round  = (MUL_P_W+1)'(mul_prod) + (MUL_P_W+1)'(1 << 16);
            t_shift  = t_round >> 17;
         end
         STEP_TANG: begin
            gain_sel = gain_ang_ff;
            x_neg    = adiff_ff[17];
            x_mag    = adiff_ff[17] ? 48'(-19'(adiff_ff)) : 48'(adiff_ff);
            t_round  = (MUL_P_W+1)'(mul_prod) + (MUL_P_W+1)'(1 << 7);
            t_shift  = t_round >> 8;
         end
         STEP_TRATE: begin
            gain_sel = gain_rate_ff;
            x_neg    = rate_ff[15];
            x_mag    = rate_ff[15] ? 48'(-17'(rate_ff)) : 48'(rate_ff);
            t_round  = (MUL_P_W+1)'(mul_prod) + (MUL_P_W+1)'(1 << 3);
            t_shift  = t_round >> 4;
         end
         STEP_TACC: begin
            gain_sel = gain_acc_ff;
            x_neg    = sa_ff[47];
            x_mag    = sa_ff[47] ? 48'(-sa_ff) : 48'(sa_ff);
            t_round  = (MUL_P_W+1)'(mul_prod) + (MUL_P_W+1)'(1 << 19);
            t_shift  = t_round >> 20;
         end
         default: begin
            t_shift = '0;
         end
      endcase
      gain_mag = gain_sel[31] ? 32'(-33'(gain_sel)) : 32'(gain_sel);
   end

   // clamp the term to the limit; it is negated as the feedback sign
   always_comb begin
      t_big    = |t_shift[MUL_P_W:29];
      t_gt_lim = t_big || (t_shift[28:0] > {1'b0, lim});
      t_gt_sat = t_big || (t_shift[28:0] > lim_sat);
      t_mag    = t_gt_lim ? lim : t_shift[27:0];
      term     = (gain_sel[31] ^ x_neg) ? 32'(t_mag) : -32'(t_mag);
   end

   always_comb begin
      mul_start = 1'b0;
      div_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      if (state_ff == ST_RUN) begin
         case (step_ff)
            STEP_VNUM: begin
               mul_start = 1'b1;
               mul_a     = MUL_A_W'(vdiff_mag);
               mul_b     = US_PER_S;
            end
            STEP_ANUM: begin
               mul_start = 1'b1;
               mul_a     = MUL_A_W'(rdiff_mag);
               mul_b     = US_PER_S;
            end
            STEP_VDIV, STEP_ADIV: begin
               div_start = 1'b1;
            end
            STEP_VFLT: begin
               mul_start = 1'b1;
               mul_a     = fdiff_mag;
               mul_b     = 32'(vel_beta_ff);
            end
            STEP_AFLT: begin
               mul_start = 1'b1;
               mul_a     = fdiff_mag;
               mul_b     = 32'(acc_beta_ff);
            end
            default: begin
               mul_start = 1'b1;
               mul_a     = MUL_A_W'(x_mag);
               mul_b     = gain_mag;
            end
         endcase
      end
      unit_done = (step_ff == STEP_VDIV || step_ff == STEP_ADIV) ? div_rsp.done : mul_done;
   end

   // final limit, rounding and estimate saturation
   always_comb begin
      sum_mag  = sum_ff[31] ? 31'(-sum_ff) : 31'(sum_ff);
      sat_in   = sat_ff || (32'(sum_mag) > 32'(lim_sat));
      clip_mag = (sum_mag > 31'(lim)) ? 31'(lim) : sum_mag;
      drive_r  = (32'(clip_mag) + 32'(HALF_Q16)) >> 16;
      usum_r   = (32'(sum_mag) + 32'(HALF_Q16)) >> 16;
      drive_in = sum_ff[31] ? -13'(drive_r) : 13'(drive_r);
      usum_in  = sum_ff[31] ? -16'(usum_r) : 16'(usum_r);
      if (sv_ff[47:31] != {17{sv_ff[47]}}) begin
         vest_in = sv_ff[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         vest_in = sv_ff[31:0];
      end
      sa_mag = sa_ff[47] ? 48'(-sa_ff) : 48'(sa_ff);
      sa_r   = (49'(sa_mag) + 49'(HALF_Q16)) >> 16;
      if (sa_ff[47]) begin
         aest_in = -32'(sa_r);
      end else if (sa_r[32:31] != 2'b00) begin
         aest_in = 32'sh7fff_ffff;
      end else begin
         aest_in = 32'(sa_r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_pos_ff  <= '0;
         gain_vel_ff  <= '0;
         gain_ang_ff  <= '0;
         gain_rate_ff <= '0;
         gain_acc_ff  <= '0;
         vel_beta_ff  <= 17'd6554;
         acc_beta_ff  <= 17'd6554;
         out_limit_ff <= 12'd255;
         last_pos_ff  <= '0;
         last_rate_ff <= '0;
         sv_ff        <= '0;
         sa_ff        <= '0;
         primed_ff    <= 1'b0;
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_VNUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GAIN_POS:  gain_pos_ff  <= csr_data;
               REG_GAIN_VEL:  gain_vel_ff  <= csr_data;
               REG_GAIN_ANG:  gain_ang_ff  <= csr_data;
               REG_GAIN_RATE: gain_rate_ff <= csr_data;
               REG_GAIN_ACC:  gain_acc_ff  <= csr_data;
               REG_VEL_BETA:  vel_beta_ff  <= beta_in;
               REG_ACC_BETA:  acc_beta_ff  <= beta_in;
               REG_OUT_LIMIT: out_limit_ff <= csr_data[11:0];
               default: begin
               end
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  primed_ff <= 1'b1;
                  if (!req_sample_valid || req_restart) begin
                     // re-seed history and drive zero
                     sv_ff        <= '0;
                     sa_ff        <= '0;
                     last_pos_ff  <= pos_in;
                     last_rate_ff <= req_sample_valid ? req_tilt_rate : 16'sd0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_OUT;
                  end else begin
                     if (!primed_ff || bad_dt) begin
                        sv_ff        <= '0;
                        sa_ff        <= '0;
                        last_pos_ff  <= pos_in;
                        last_rate_ff <= req_tilt_rate;
                     end
                     step_ff  <= STEP_VNUM;
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (unit_done) begin
                  case (step_ff)
                     STEP_VFLT: sv_ff <= 48'(filt_new);
                     STEP_AFLT: sa_ff <= 48'(filt_new);
                     default: begin
                     end
                  endcase
                  if (step_ff == STEP_TACC) begin
                     state_ff <= ST_FIN;
                  end else begin
                     step_ff  <= step_ff + 4'd1;
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_FIN: begin
               last_pos_ff  <= pos_ff;
               last_rate_ff <= rate_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         pos_ff   <= pos_in;
         adiff_ff <= 18'(req_tilt_angle) - 18'(req_tilt_setpoint);
         rate_ff  <= req_tilt_rate;
         dt_ff    <= bad_dt ? DEF_DT : req_step_time_us;
         sum_ff   <= '0;
         sat_ff   <= 1'b0;
         drive_ff <= '0;
         satd_ff  <= 1'b0;
         usum_ff  <= '0;
         vest_ff  <= '0;
         aest_ff  <= '0;
         held_ff  <= 1'b1;
      end
      if (state_ff == ST_WAIT && unit_done) begin
         if (step_ff == STEP_VDIV || step_ff == STEP_ADIV) begin
            raw_ff <= diff_neg ? -48'(raw_mag) : 48'(raw_mag);
         end
         if (step_ff >= STEP_TPOS) begin
            sum_ff <= sum_ff + term;
            sat_ff <= sat_ff | t_gt_sat;
         end
      end
      if (state_ff == ST_FIN) begin
         drive_ff <= drive_in;
         satd_ff  <= sat_in;
         usum_ff  <= usum_in;
         vest_ff  <= vest_in;
         aest_ff  <= aest_in;
         held_ff  <= 1'b0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_drive             = drive_ff;
   assign rsp_saturated         = satd_ff;
   assign rsp_unlimited_sum     = usum_ff;
   assign rsp_velocity_estimate = vest_ff;
   assign rsp_accel_estimate    = aest_ff;
   assign rsp_held              = held_ff;

endmodule

@@ hdl/fsfb_checker.sv @@
// ----------------------------------------------------------------------------
// fsfb_checker
// Port-level checks on the balance controller.
// ----------------------------------------------------------------------------
module fsfb_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [12:0] rsp_drive,
   input logic               rsp_saturated,
   input logic signed [15:0] rsp_unlimited_sum,
   input logic               rsp_held
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("new sample taken while one is in progress");

   a_busy_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("sample taken while a result waits");

   a_held_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_held |-> rsp_drive == 13'sd0 && !rsp_saturated
                                && rsp_unlimited_sum == 16'sd0)
      else $error("held result with non-zero drive");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive))
      else $error("stalled result changed");

endmodule

bind full_state_feedback_balance fsfb_checker u_fsfb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_drive         (rsp_drive),
   .rsp_saturated     (rsp_saturated),
   .rsp_unlimited_sum (rsp_unlimited_sum),
   .rsp_held          (rsp_held)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the balance controller. A directed table, then
// random samples under several register settings; every transfer on the
// result channel is compared with a fixed table value or a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_top;
   import fsfb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          DEFAULT_PERIOD = 10000;
   localparam int          MAX_STEP       = 100000;
   localparam int          DRIVE_CAP      = 4095;
   localparam longint      TIMEOUT_CYCLES = 3000000;
   localparam int          PHASES         = 8;
   localparam int          PHASE_ITEMS    = 154;
   localparam longint unsigned MAG_LIMIT  = 64'h4000_0000_0000_0000;
   localparam longint      RATE_SAT       = (64'sd1 <<< 47) - 1;

   typedef enum logic [2:0] {
      REG_GAIN_POS, REG_GAIN_VEL, REG_GAIN_ANGLE, REG_GAIN_RATE,
      REG_GAIN_ACCEL, REG_VEL_BETA, REG_ACCEL_BETA, REG_LIMIT
   } csr_reg_e;

   typedef struct packed {
      logic signed [31:0] left_count;
      logic signed [31:0] right_count;
      logic signed [16:0] tilt_angle;
      logic signed [16:0] tilt_setpoint;
      logic signed [15:0] tilt_rate;
      logic [19:0]        step_time_us;
      logic               sample_valid;
      logic               restart;
   } sample_t;

   typedef struct packed {
      logic signed [12:0] drive;
      logic               saturated;
      logic signed [15:0] unlimited_sum;
      logic signed [31:0] velocity_estimate;
      logic signed [31:0] accel_estimate;
      logic               held;
   } control_t;

   typedef struct {
      int       preset;     // register preset applied first, -1 for none
      sample_t  smp;
      bit       typed;
      control_t want;
   } table_row_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_left_count = '0;
   logic signed [31:0] req_right_count = '0;
   logic signed [16:0] req_tilt_angle = '0;
   logic signed [16:0] req_tilt_setpoint = '0;
   logic signed [15:0] req_tilt_rate = '0;
   logic [19:0]        req_step_time_us = '0;
   logic               req_sample_valid = 1'b0;
   logic               req_restart = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [12:0] rsp_drive;
   logic               rsp_saturated;
   logic signed [15:0] rsp_unlimited_sum;
   logic signed [31:0] rsp_velocity_estimate;
   logic signed [31:0] rsp_accel_estimate;
   logic               rsp_held;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   full_state_feedback_balance u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor registers and history
   longint      k_pos, k_vel, k_angle, k_rate, k_accel;
   int unsigned vel_beta, accel_beta, out_limit;
   longint      prev_position, prev_rate, vel_filt, accel_filt;
   bit          seeded;

   control_t    pending_controls[$];
   int          mismatches = 0;
   bit          calm = 1'b0;
   int          stall_left = 0;
   longint      cycles = 0;
   longint      enc_l = 0, enc_r = 0;
   table_row_t  rows[$];

   function automatic longint unsigned magnitude(longint x);
      return x < 0 ? 64'd0 - 64'(x) : 64'(x);
   endfunction

   function automatic longint signed_by(longint unsigned m, bit neg);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint round_half_away(longint v);
      return signed_by((magnitude(v) + 64'd32768) >> 16, v < 0);
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint feedback_term(longint gain, longint x, int sh,
                                            longint unsigned lim, inout bit sat);
      logic [127:0]    prod;
      longint unsigned m;
      prod = ({64'd0, magnitude(gain)} * {64'd0, magnitude(x)}
              + (128'd1 << (sh - 1))) >> sh;
      m = (prod > MAG_LIMIT) ? MAG_LIMIT : prod[63:0];
      if (m > lim) begin
         if (m - lim > 64'd32768) sat = 1'b1;
         m = lim;
      end
      // the controller feeds back the negated product
      return signed_by(m, (gain < 0) == (x < 0));
   endfunction

   function automatic longint rate_of_change(longint diff, int unsigned dt);
      longint unsigned num, q, r, res;
      num = magnitude(diff) * 64'd1000000;
      q = num / dt;
      r = num % dt;
      if (q >= 64'd1 << 31) res = RATE_SAT;
      else res = (q << 16) + (r << 16) / dt;
      return signed_by(res, diff < 0);
   endfunction

   function automatic longint low_pass(longint s, longint raw, int unsigned beta);
      longint          d;
      longint unsigned stp;
      d = raw - s;
      stp = (magnitude(d) * beta + 64'd32768) >> 16;
      return s + signed_by(stp, d < 0);
   endfunction

   function automatic int unsigned beta_of(logic [31:0] v);
      int unsigned b;
      b = v[16:0];
      return b < 1 ? 1 : (b > 65536 ? 65536 : b);
   endfunction

   function automatic control_t balance_step(sample_t s);
      longint          pos, ang, setp, rte, sum, drv;
      longint unsigned lim;
      int unsigned     dt;
      bit              sat;
      control_t        c;
      pos = longint'(s.left_count) + longint'(s.right_count);
      ang = s.tilt_angle;
      setp = s.tilt_setpoint;
      rte = s.tilt_rate;
      dt = s.step_time_us;
      sat = 1'b0;
      c = '0;
      if (!s.sample_valid || s.restart) begin
         vel_filt = 0;
         accel_filt = 0;
         prev_position = pos;
         prev_rate = s.sample_valid ? rte : 0;
         seeded = 1'b1;
         c.held = 1'b1;
         return c;
      end
      if (!seeded) begin
         vel_filt = 0;
         accel_filt = 0;
         prev_position = pos;
         prev_rate = rte;
         seeded = 1'b1;
      end
      // out-of-range step: fall back to the default period, clear filters
      if (dt == 0 || dt > MAX_STEP) begin
         dt = DEFAULT_PERIOD;
         prev_position = pos;
         prev_rate = rte;
         vel_filt = 0;
         accel_filt = 0;
      end
      vel_filt = low_pass(vel_filt, rate_of_change(pos - prev_position, dt), vel_beta);
      accel_filt = low_pass(accel_filt, rate_of_change(rte - prev_rate, dt), accel_beta);
      prev_position = pos;
      prev_rate = rte;
      lim = 64'(out_limit < DRIVE_CAP ? out_limit : DRIVE_CAP) << 16;
      sum = feedback_term(k_pos, pos, 1, lim, sat)
          + feedback_term(k_vel, vel_filt, 17, lim, sat)
          + feedback_term(k_angle, ang - setp, 8, lim, sat)
          + feedback_term(k_rate, rte, 4, lim, sat)
          + feedback_term(k_accel, accel_filt, 20, lim, sat);
      if (magnitude(sum) > lim && magnitude(sum) - lim > 64'd32768) sat = 1'b1;
      drv = round_half_away(clamp(sum, -longint'(lim), longint'(lim)));
      c.drive = drv[12:0];
      c.saturated = sat;
      c.unlimited_sum = 16'(round_half_away(sum));
      c.velocity_estimate = 32'(clamp(vel_filt, -64'sd2147483648, 64'sd2147483647));
      c.accel_estimate = 32'(clamp(round_half_away(accel_filt),
                                   -64'sd2147483648, 64'sd2147483647));
      return c;
   endfunction

   task automatic csr_write(csr_reg_e idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_GAIN_POS:   k_pos = longint'(signed'(value));
         REG_GAIN_VEL:   k_vel = longint'(signed'(value));
         REG_GAIN_ANGLE: k_angle = longint'(signed'(value));
         REG_GAIN_RATE:  k_rate = longint'(signed'(value));
         REG_GAIN_ACCEL: k_accel = longint'(signed'(value));
         REG_VEL_BETA:   vel_beta = beta_of(value);
         REG_ACCEL_BETA: accel_beta = beta_of(value);
         REG_LIMIT:      out_limit = value[11:0];
         default: ;
      endcase
   endtask

   // hold the request side until every control has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_controls.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_regs(logic [31:0] gp, logic [31:0] gv, logic [31:0] ga,
                            logic [31:0] gr, logic [31:0] gacc, logic [31:0] vb,
                            logic [31:0] ab, logic [31:0] lim);
      drain();
      csr_write(REG_GAIN_POS, gp);
      csr_write(REG_GAIN_VEL, gv);
      csr_write(REG_GAIN_ANGLE, ga);
      csr_write(REG_GAIN_RATE, gr);
      csr_write(REG_GAIN_ACCEL, gacc);
      csr_write(REG_VEL_BETA, vb);
      csr_write(REG_ACCEL_BETA, ab);
      csr_write(REG_LIMIT, lim);
   endtask

   task automatic send_sample(sample_t s, bit typed, control_t want);
      control_t c;
      req_valid <= 1'b1;
      req_left_count <= s.left_count;
      req_right_count <= s.right_count;
      req_tilt_angle <= s.tilt_angle;
      req_tilt_setpoint <= s.tilt_setpoint;
      req_tilt_rate <= s.tilt_rate;
      req_step_time_us <= s.step_time_us;
      req_sample_valid <= s.sample_valid;
      req_restart <= s.restart;
      do @(posedge clock); while (req_stall);
      c = balance_step(s);
      pending_controls.push_back(typed ? want : c);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_gain();
      logic [31:0] g;
      case ($urandom_range(0, 4))
         0: g = $urandom_range(0, 255);
         1: g = $urandom_range(0, 1 << 16);
         2: g = $urandom_range(0, 1 << 22);
         3: g = $urandom;
         default: g = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
      if ($urandom_range(0, 1) != 0) g = -g;
      return g;
   endfunction

   function automatic logic [31:0] pick_beta();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'h0001_ffff;
         2: return 32'd65536;
         3: return $urandom_range(1, 65536);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return 32'h0000_0fff;
         2: return 32'd255;
         default: return $urandom;
      endcase
   endfunction

   function automatic sample_t random_sample();
      sample_t s;
      if ($urandom_range(0, 19) == 0) begin
         enc_l = signed'($urandom);
         enc_r = signed'($urandom);
      end else begin
         enc_l += longint'($urandom_range(0, 4000)) - 2000;
         enc_r += longint'($urandom_range(0, 4000)) - 2000;
         if ($urandom_range(0, 15) == 0) enc_l += longint'($urandom_range(0, 200000)) - 100000;
      end
      s.left_count = 32'(enc_l);
      s.right_count = 32'(enc_r);
      enc_l = longint'(s.left_count);
      enc_r = longint'(s.right_count);
      s.tilt_angle = 17'(int'($urandom_range(0, 92160)) - 46080);
      if ($urandom_range(0, 3) == 0)
         s.tilt_setpoint = 17'(int'($urandom_range(0, 92160)) - 46080);
      else
         s.tilt_setpoint = 17'(int'($urandom_range(0, 5120)) - 2560);
      s.tilt_rate = $urandom_range(0, 65535);
      case ($urandom_range(0, 15))
         0: s.step_time_us = 0;
         1: s.step_time_us = $urandom;
         2: s.step_time_us = MAX_STEP + $urandom_range(0, 1);
         3: s.step_time_us = $urandom_range(1, 10);
         default: s.step_time_us = $urandom_range(1000, 20000);
      endcase
      s.sample_valid = ($urandom_range(0, 15) != 0);
      s.restart = ($urandom_range(0, 23) == 0);
      return s;
   endfunction

   function automatic sample_t mk(longint l, longint r, int a, int sp, int rt, int dt,
                                  bit v, bit rs);
      sample_t s;
      s.left_count = 32'(l);
      s.right_count = 32'(r);
      s.tilt_angle = 17'(a);
      s.tilt_setpoint = 17'(sp);
      s.tilt_rate = 16'(rt);
      s.step_time_us = 20'(dt);
      s.sample_valid = v;
      s.restart = rs;
      return s;
   endfunction

   function automatic void add_row(int preset, sample_t s, bit typed, control_t want);
      table_row_t t;
      t.preset = preset;
      t.smp = s;
      t.typed = typed;
      t.want = want;
      rows.push_back(t);
   endfunction

   task automatic apply_preset(int id);
      case (id)
         0: load_regs(32'h0000_8000, 32'h0000_0010, 32'h0002_0000, 32'hffff_0000,
                      32'h0000_0100, 32'h0001_ffff, 32'd0, 32'h0000_0fff);
         1: load_regs(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                      32'h8000_0000, 32'd65536, 32'd6554, 32'd0);
         default: load_regs(32'hfffe_0000, 32'h0000_0100, 32'h0000_4000, 32'h0000_2000,
                            32'hffff_ff00, 32'd1, 32'd65536, 32'd255);
      endcase
   endtask

   // result channel: random stall bursts
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      control_t want, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_drive, rsp_saturated, rsp_unlimited_sum, rsp_velocity_estimate,
                 rsp_accel_estimate, rsp_held};
         if (pending_controls.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected control transfer %p", got);
         end else begin
            want = pending_controls.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("control mismatch: expected %p, actual %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > TIMEOUT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      control_t zero_out, held_out;
      zero_out = '0;
      held_out = '0;
      held_out.held = 1'b1;
      k_pos = 0; k_vel = 0; k_angle = 0; k_rate = 0; k_accel = 0;
      vel_beta = 6554; accel_beta = 6554; out_limit = 255;
      prev_position = 0; prev_rate = 0; vel_filt = 0; accel_filt = 0; seeded = 1'b0;

      // reset gains are zero: first sample gives nothing, held samples flag
      add_row(-1, mk(5, 7, 1000, 0, 300, 10000, 1, 0), 1, zero_out);
      add_row(-1, mk(-1, 1, 0, 0, 0, 5000, 0, 0), 1, held_out);
      add_row(-1, mk(100, 100, 50, 0, -20, 5000, 1, 1), 1, held_out);
      add_row(0, mk(2147483647, 2147483647, 46080, -46080, 32767, 1, 1, 0), 0, zero_out);
      add_row(-1, mk(-2147483648, -2147483648, -46080, 46080, -32768, 100000, 1, 0),
              0, zero_out);
      add_row(-1, mk(2147483647, -2147483648, 100, 0, 500, 1, 1, 0), 0, zero_out);
      add_row(-1, mk(10, 12, 100, 0, 500, 0, 1, 0), 0, zero_out);
      add_row(-1, mk(40, 42, 120, 10, 510, 100001, 1, 0), 0, zero_out);
      add_row(-1, mk(80, 90, 140, 10, 520, 1048575, 1, 0), 0, zero_out);
      add_row(-1, mk(180, 190, 160, 10, 700, 5000, 1, 0), 0, zero_out);
      add_row(-1, mk(300, 290, 200, 10, -700, 5000, 1, 0), 0, zero_out);
      add_row(-1, mk(400, 400, 200, 10, 900, 5000, 0, 1), 1, held_out);
      add_row(-1, mk(500, 500, 200, 10, 900, 5000, 1, 0), 0, zero_out);
      add_row(-1, mk(600, 600, 200, 10, 999, 5000, 0, 0), 1, held_out);
      add_row(1, mk(1000, -3000, 46080, -46080, 32767, 2000, 1, 0), 0, zero_out);
      add_row(-1, mk(1200, -2800, -46080, 46080, -32768, 2000, 1, 0), 0, zero_out);
      add_row(-1, mk(0, 0, 0, 0, 0, 2000, 1, 0), 0, zero_out);
      add_row(2, mk(-50, 70, 3000, 256, -4000, 10000, 1, 0), 0, zero_out);
      add_row(-1, mk(-30, 90, 3100, 256, -3900, 9000, 1, 0), 0, zero_out);
      add_row(-1, mk(-10, 110, 3200, 256, -3800, 8000, 1, 0), 0, zero_out);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].preset >= 0) apply_preset(rows[i].preset);
         send_sample(rows[i].smp, rows[i].typed, rows[i].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            1: load_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                         pick_beta(), pick_beta(), 32'd0);
            2: load_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                         32'd1, 32'd65536, 32'h0000_0fff);
            default: load_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                               pick_gain(), pick_beta(), pick_beta(), pick_limit());
         endcase
         calm = (p == 4 || p == PHASES - 1);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_sample(random_sample(), 1'b0, zero_out);
      end

      req_valid <= 1'b0;
      while (pending_controls.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ full_state_feedback_balance.f @@
hdl/fsfb_pkg.sv
hdl/fsfb_mul.sv
hdl/fsfb_div.sv
hdl/full_state_feedback_balance.sv
hdl/fsfb_checker.sv
test/tb_top.sv
